@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define SBQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define SBQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Delayed implication, disabled while rst is high.
`define SBQ_ASSERT_NXT2(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
      else $error(msg);

`endif

@@ sv/sbq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_pkg
// Types, coefficient tables and fixed-point constants of the bandpass biquad.
// ----------------------------------------------------------------------------
package sbq_pkg;

   localparam int NUM_BANDS   = 4;
   localparam int FRAC_BITS   = 16;
   localparam int STATE_WIDTH = 32;
   localparam int COEF_BITS   = 14;
   localparam int RECIP_BITS  = 24;
   localparam int TABLE_DEPTH = 4;

   typedef logic        [1:0]  band_type;
   typedef logic signed [7:0]  sample_type;
   typedef logic signed [24:0] recip_type;
   typedef logic signed [15:0] coef_type;

   // 1/gain in Q24
   localparam recip_type RECIP_GAIN [TABLE_DEPTH] = '{
      25'sd2813596, 25'sd1504422, 25'sd2784053, 25'sd4052381
   };

   // feedback on y delayed two, Q14
   localparam coef_type COEF_A [TABLE_DEPTH] = '{
      -16'sd10947, -16'sd13446, -16'sd10947, -16'sd8757
   };

   // feedback on y delayed one, Q14
   localparam coef_type COEF_B [TABLE_DEPTH] = '{
      16'sd23170, 16'sd8701, -16'sd5437, -16'sd23170
   };

endpackage

@@ sv/sbq_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_scale
// Scales a raw sample by the band's reciprocal gain into the state format.
// ----------------------------------------------------------------------------
module sbq_scale #(
   parameter int FRAC_BITS   = sbq_pkg::FRAC_BITS,
   parameter int STATE_WIDTH = sbq_pkg::STATE_WIDTH
) (
   input  sbq_pkg::sample_type     sample_in,
   input  sbq_pkg::band_type       band,
   output logic signed [STATE_WIDTH-1:0] scaled
);
   import sbq_pkg::*;

   localparam int PW        = 34;
   localparam int SHIFT     = RECIP_BITS - FRAC_BITS;
   localparam logic signed [PW-1:0] HALF = (PW'(1) << SHIFT) >>> 1;

   logic signed [32:0]   prod;
   logic signed [PW-1:0] rounded;

   always_comb begin
      prod    = sample_in * RECIP_GAIN[band];
      rounded = (PW'(prod) + HALF) >>> SHIFT;
      scaled  = STATE_WIDTH'(rounded);
   end

endmodule

@@ sv/sbq_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_core
// Recursion of the biquad: holds the delay line and forms the next output.
// ----------------------------------------------------------------------------
module sbq_core #(
   parameter int STATE_WIDTH = sbq_pkg::STATE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic signed [STATE_WIDTH-1:0] scaled,
   input  sbq_pkg::band_type             band,
   output logic signed [STATE_WIDTH-1:0] y_next
);
   import sbq_pkg::*;

   localparam int W  = STATE_WIDTH;
   localparam int AW = STATE_WIDTH + 18;
   localparam logic signed [AW-1:0] HALF = (AW'(1) << COEF_BITS) >>> 1;

   logic signed [W-1:0]  x_d1_ff, x_d2_ff, y_d1_ff, y_d2_ff;
   logic signed [W+15:0] prod_a, prod_b;
   logic signed [AW-1:0] fb_sum, fb_scaled, y_full;

   always_comb begin
      prod_a    = COEF_A[band] * y_d2_ff;
      prod_b    = COEF_B[band] * y_d1_ff;
      fb_sum    = AW'(prod_a) + AW'(prod_b) + HALF;
      fb_scaled = fb_sum >>> COEF_BITS;
      y_full    = AW'(scaled) - AW'(x_d2_ff) + fb_scaled;
      y_next    = W'(y_full);
   end

   // shift the delay line once per word
   always_ff @(posedge clock) begin
      if (reset) begin
         x_d1_ff <= '0;
         x_d2_ff <= '0;
         y_d1_ff <= '0;
         y_d2_ff <= '0;
      end else if (advance) begin
         x_d2_ff <= x_d1_ff;
         x_d1_ff <= scaled;
         y_d2_ff <= y_d1_ff;
         y_d1_ff <= y_next;
      end
   end

endmodule

@@ sv/sbq_sat.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_sat
// Converts a state-format value to an 8-bit sample: truncate toward zero,
// then saturate.
// ----------------------------------------------------------------------------
module sbq_sat #(
   parameter int FRAC_BITS   = sbq_pkg::FRAC_BITS,
   parameter int STATE_WIDTH = sbq_pkg::STATE_WIDTH
) (
   input  logic signed [STATE_WIDTH-1:0] y,
   output sbq_pkg::sample_type           sample_out
);
   import sbq_pkg::*;

   localparam int QW = STATE_WIDTH + 1;
   localparam logic signed [QW-1:0] BIAS = (QW'(1) << FRAC_BITS) - QW'(1);
   localparam logic signed [QW-1:0] QMAX = QW'(127);
   localparam logic signed [QW-1:0] QMIN = -QW'(128);

   logic signed [QW-1:0] biased, q;

   always_comb begin
      // bias negatives so the arithmetic shift rounds toward zero
      biased = QW'(y) + (y[STATE_WIDTH-1] ? BIAS : '0);
      q      = biased >>> FRAC_BITS;
      if (q > QMAX) begin
         sample_out = 8'sd127;
      end else if (q < QMIN) begin
         sample_out = -8'sd128;
      end else begin
         sample_out = 8'(q);
      end
   end

endmodule

@@ sv/switchable_biquad_bandpass_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// switchable_biquad_bandpass_top
// Second-order bandpass IIR with four selectable bands, 8-bit in and out.
// ----------------------------------------------------------------------------
// The block takes one signed 8-bit sample and a band select per word and
// returns one filtered signed 8-bit sample per word, in order. It accepts a
// new word every clock cycle while rsp_stall is low. An accepted word sits in
// the input register and is then loaded into the result register, where it
// shows on rsp_valid; it waits in the input register while rsp_stall holds a
// full result register, and in the result register while rsp_stall is high.
// The input register already carries the sample scaled by the band's
// reciprocal gain; the feedback recursion (two coefficient multiplies and the
// sum into the delay line) sits between the input and result registers, and
// it is that loop through the stored outputs that sets the rate. A band
// select at or above the number of bands uses the last band. Filter state is
// wide and never clipped; only the output is truncated toward zero and
// saturated to -128..127. Reset clears the delay line to zero.
// ----------------------------------------------------------------------------
module switchable_biquad_bandpass_top #(
   parameter int FRAC_BITS   = sbq_pkg::FRAC_BITS,
   parameter int STATE_WIDTH = sbq_pkg::STATE_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sbq_pkg::sample_type req_sample_in,
   input  sbq_pkg::band_type   req_mode,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sbq_pkg::sample_type rsp_sample_out
);
   import sbq_pkg::*;

   logic                          in_vld_ff, in_vld_in;
   logic                          rsp_vld_ff, rsp_vld_in;
   logic signed [STATE_WIDTH-1:0] in_x_ff, rsp_y_ff;
   band_type                      in_band_ff;
   band_type                      band_sel;
   logic signed [STATE_WIDTH-1:0] x_scaled, y_next;
   logic                          req_accept, advance;

   // clamp an out-of-range band to the last one
   assign band_sel = (4'(req_mode) >= 4'(NUM_BANDS)) ? 2'(NUM_BANDS - 1) : req_mode;

   // advance the input word when the result register is empty or draining
   assign advance    = in_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall  = in_vld_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_vld_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
      rsp_vld_in = advance ? 1'b1 : (rsp_stall ? rsp_vld_ff : 1'b0);
   end

   // scale at the port so the input register holds x directly
   sbq_scale #(
      .FRAC_BITS   (FRAC_BITS),
      .STATE_WIDTH (STATE_WIDTH)
   ) u_sbq_scale (
      .sample_in (req_sample_in),
      .band      (band_sel),
      .scaled    (x_scaled)
   );

   sbq_core #(
      .STATE_WIDTH (STATE_WIDTH)
   ) u_sbq_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .scaled  (in_x_ff),
      .band    (in_band_ff),
      .y_next  (y_next)
   );

   sbq_sat #(
      .FRAC_BITS   (FRAC_BITS),
      .STATE_WIDTH (STATE_WIDTH)
   ) u_sbq_sat (
      .y          (rsp_y_ff),
      .sample_out (rsp_sample_out)
   );

   // handshake control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload: load on accept / advance, hold otherwise
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_x_ff    <= x_scaled;
         in_band_ff <= band_sel;
      end
      if (advance) begin
         rsp_y_ff <= y_next;
      end
   end

   assign rsp_valid = rsp_vld_ff;

endmodule

@@ sv/sbq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_checker
// Port-level checks of the bandpass biquad, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sbq_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input sbq_pkg::sample_type rsp_sample_out
);

   // a stalled result holds its word
   `SBQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_sample_out), "stalled result word changed")

   // reset empties the result register
   `SBQ_ASSERT_NXT(a_rst_empty, clock, 1'b0, reset, !rsp_valid, "result valid right after reset")

   // the block is ready for a word straight out of reset
   `SBQ_ASSERT_IMP(a_rst_ready, clock, 1'b0, $past(reset), !req_stall, "input stalled right after reset")

   // after a word is accepted, the result register holds a word
   `SBQ_ASSERT_NXT2(a_latency, clock, reset, req_valid && !req_stall, rsp_valid, "accepted word did not reach the result register")

endmodule

bind switchable_biquad_bandpass_top sbq_checker u_sbq_checker (.*);
